// ===== sv/tmi_pkg.sv =====
// shared constants, codes and controller/datapath interface types
package tmi_pkg;

   localparam int PROG_DEPTH = 4096;
   localparam int PROG_AW    = $clog2(PROG_DEPTH);
   localparam int TAPE_CELLS = 4096;
   localparam int TAPE_AW    = $clog2(TAPE_CELLS);
   localparam int LOOP_NEST  = 64;
   localparam int STACK_AW   = $clog2(LOOP_NEST);
   localparam int DEPTH_W    = STACK_AW + 1;
   localparam int PC_W       = 13;
   localparam int CELL_W     = 8;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_STEP    = 2'd1,
      OP_RESTART = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      SYM_RIGHT = 3'd0,
      SYM_LEFT  = 3'd1,
      SYM_INC   = 3'd2,
      SYM_DEC   = 3'd3,
      SYM_PRINT = 3'd4,
      SYM_READ  = 3'd5,
      SYM_OPEN  = 3'd6,
      SYM_CLOSE = 3'd7
   } symbol_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_END       = 2'd1,
      STAT_UNMATCHED = 2'd2,
      STAT_OVERFLOW  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR_INIT,
      ST_IDLE,
      ST_FETCH,
      ST_EXEC,
      ST_SCAN_ISSUE,
      ST_SCAN_CHECK,
      ST_CLEAR_RUN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic load;
      logic restart;
      logic exec;
      logic scan_issue;
      logic scan_check;
      logic clear;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic need_scan;
      logic scan_end;
      logic scan_hit;
      logic clear_last;
      logic out_free;
   } stat_type;

endpackage

// ===== sv/tmi_ctrl.sv =====
// sequencing state machine of the interpreter
module tmi_ctrl import tmi_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_opcode,
   input  stat_type   stat,
   output logic       req_stall,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign accept = (state_ff == ST_IDLE) && req_valid;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR_INIT: if (stat.clear_last) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_valid) begin
               unique case (opcode_type'(req_opcode))
                  OP_STEP:    state_in = ST_FETCH;
                  OP_RESTART: state_in = ST_CLEAR_RUN;
                  OP_LOAD:    state_in = ST_DONE;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_FETCH:      state_in = ST_EXEC;
         ST_EXEC:       state_in = stat.need_scan ? ST_SCAN_ISSUE : ST_DONE;
         ST_SCAN_ISSUE: state_in = stat.scan_end ? ST_DONE : ST_SCAN_CHECK;
         ST_SCAN_CHECK: state_in = stat.scan_hit ? ST_DONE : ST_SCAN_ISSUE;
         ST_CLEAR_RUN:  if (stat.clear_last) state_in = ST_DONE;
         ST_DONE:       if (stat.out_free) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall      = (state_ff != ST_IDLE);
      cmd            = '0;
      cmd.accept     = accept;
      cmd.load       = accept && (req_opcode == OP_LOAD);
      cmd.restart    = accept && (req_opcode == OP_RESTART);
      cmd.exec       = (state_ff == ST_EXEC);
      cmd.scan_issue = (state_ff == ST_SCAN_ISSUE);
      cmd.scan_check = (state_ff == ST_SCAN_CHECK);
      cmd.clear      = (state_ff == ST_CLEAR_INIT) || (state_ff == ST_CLEAR_RUN);
      cmd.emit       = (state_ff == ST_DONE) && stat.out_free;
   end

endmodule

// ===== sv/tmi_dp.sv =====
// interpreter datapath: program store, tape, loop stack, counters and result register
module tmi_dp import tmi_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output stat_type            stat,
   input  logic                csr_wr_en,
   input  logic [PC_W-1:0]     csr_wr_data,
   input  logic [PROG_AW-1:0]  req_prog_addr,
   input  logic [2:0]          req_symbol,
   input  logic [CELL_W-1:0]   req_in_byte,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic                rsp_out_valid,
   output logic [CELL_W-1:0]   rsp_out_byte,
   output logic [1:0]          rsp_status,
   output logic [PC_W-1:0]     rsp_next_pc,
   output logic [TAPE_AW-1:0]  rsp_cell_pointer
);

   localparam logic [TAPE_AW-1:0] TapeMax = TAPE_AW'(TAPE_CELLS - 1);
   localparam logic [PC_W-1:0]    RunMax  = PC_W'(PROG_DEPTH);
   localparam logic [PC_W-1:0]    NestOne = PC_W'(1);

   logic [2:0]         prog_mem  [PROG_DEPTH];
   logic [CELL_W-1:0]  tape_mem  [TAPE_CELLS];
   logic [PROG_AW-1:0] stack_mem [LOOP_NEST];

   logic [PC_W-1:0]    plen_ff, pc_ff, pc_in, scan_ff, scan_in, nest_ff, nest_in;
   logic [TAPE_AW-1:0] ptr_ff, ptr_in, clr_ff, clr_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic               rsp_valid_ff;

   logic [2:0]         prog_rd_ff;
   logic [CELL_W-1:0]  tape_rd_ff;
   logic [PROG_AW-1:0] stack_rd_ff;
   logic [CELL_W-1:0]  in_byte_ff, in_byte_in;
   logic               res_ov_ff, res_ov_in;
   logic [CELL_W-1:0]  res_byte_ff, res_byte_in;
   status_type         res_st_ff, res_st_in;

   logic               rsp_out_valid_ff;
   logic [CELL_W-1:0]  rsp_out_byte_ff;
   status_type         rsp_status_ff;
   logic [PC_W-1:0]    rsp_next_pc_ff;
   logic [TAPE_AW-1:0] rsp_cell_pointer_ff;

   logic [PC_W-1:0]    run_len;
   logic               at_end, cell_zero, stack_empty, stack_full;
   symbol_type         sym;
   logic [PROG_AW-1:0] prog_raddr;
   logic [STACK_AW-1:0] top_idx;
   logic               tape_we, stack_we;
   logic [TAPE_AW-1:0] tape_waddr;
   logic [CELL_W-1:0]  tape_wdata;

   assign run_len     = (plen_ff > RunMax) ? RunMax : plen_ff;
   assign at_end      = (pc_ff >= run_len);
   assign sym         = symbol_type'(prog_rd_ff);
   assign cell_zero   = (tape_rd_ff == '0);
   assign stack_empty = (depth_ff == '0);
   assign stack_full  = (depth_ff == DEPTH_W'(LOOP_NEST));
   assign prog_raddr  = cmd.scan_issue ? scan_ff[PROG_AW-1:0] : pc_ff[PROG_AW-1:0];
   assign top_idx     = STACK_AW'(depth_ff - 1'b1);

   // memories, read data registered
   always_ff @(posedge clock) begin
      if (cmd.load) prog_mem[req_prog_addr] <= req_symbol;
      prog_rd_ff <= prog_mem[prog_raddr];
   end

   always_ff @(posedge clock) begin
      if (tape_we) tape_mem[tape_waddr] <= tape_wdata;
      tape_rd_ff <= tape_mem[ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (stack_we) stack_mem[depth_ff[STACK_AW-1:0]] <= pc_ff[PROG_AW-1:0];
      stack_rd_ff <= stack_mem[top_idx];
   end

   always_comb begin
      pc_in       = pc_ff;
      ptr_in      = ptr_ff;
      depth_in    = depth_ff;
      scan_in     = scan_ff;
      nest_in     = nest_ff;
      clr_in      = '0;
      in_byte_in  = in_byte_ff;
      res_ov_in   = res_ov_ff;
      res_byte_in = res_byte_ff;
      res_st_in   = res_st_ff;
      tape_we     = 1'b0;
      tape_waddr  = ptr_ff;
      tape_wdata  = tape_rd_ff;
      stack_we    = 1'b0;

      if (cmd.clear) begin
         tape_we    = 1'b1;
         tape_waddr = clr_ff;
         tape_wdata = '0;
         clr_in     = clr_ff + 1'b1;
      end

      if (cmd.accept) begin
         in_byte_in  = req_in_byte;
         res_ov_in   = 1'b0;
         res_byte_in = '0;
         res_st_in   = STAT_OK;
      end

      if (cmd.restart) begin
         pc_in    = '0;
         ptr_in   = '0;
         depth_in = '0;
      end

      if (cmd.exec) begin
         scan_in = pc_ff + 1'b1;
         nest_in = NestOne;
         if (at_end) begin
            res_st_in = STAT_END;
         end else begin
            unique case (sym)
               SYM_RIGHT: begin
                  if (ptr_ff != TapeMax) ptr_in = ptr_ff + 1'b1;
                  pc_in = pc_ff + 1'b1;
               end
               SYM_LEFT: begin
                  if (ptr_ff != '0) ptr_in = ptr_ff - 1'b1;
                  pc_in = pc_ff + 1'b1;
               end
               SYM_INC: begin
                  tape_we    = 1'b1;
                  tape_wdata = tape_rd_ff + 1'b1;
                  pc_in      = pc_ff + 1'b1;
               end
               SYM_DEC: begin
                  tape_we    = 1'b1;
                  tape_wdata = tape_rd_ff - 1'b1;
                  pc_in      = pc_ff + 1'b1;
               end
               SYM_PRINT: begin
                  res_ov_in   = 1'b1;
                  res_byte_in = tape_rd_ff;
                  pc_in       = pc_ff + 1'b1;
               end
               SYM_READ: begin
                  tape_we    = 1'b1;
                  tape_wdata = in_byte_ff;
                  pc_in      = pc_ff + 1'b1;
               end
               SYM_OPEN: begin
                  // zero cell: the forward scan takes over
                  if (!cell_zero) begin
                     if (stack_full) begin
                        res_st_in = STAT_OVERFLOW;
                     end else begin
                        stack_we = 1'b1;
                        depth_in = depth_ff + 1'b1;
                        pc_in    = pc_ff + 1'b1;
                     end
                  end
               end
               SYM_CLOSE: begin
                  if (stack_empty) begin
                     res_st_in = STAT_UNMATCHED;
                  end else if (!cell_zero) begin
                     pc_in = PC_W'(stack_rd_ff) + 1'b1;
                  end else begin
                     depth_in = depth_ff - 1'b1;
                     pc_in    = pc_ff + 1'b1;
                  end
               end
               default: res_st_in = res_st_ff;
            endcase
         end
      end

      if (cmd.scan_issue && (scan_ff >= run_len)) res_st_in = STAT_UNMATCHED;

      if (cmd.scan_check) begin
         scan_in = scan_ff + 1'b1;
         if (sym == SYM_OPEN) begin
            nest_in = nest_ff + 1'b1;
         end else if (sym == SYM_CLOSE) begin
            if (nest_ff == NestOne) pc_in = scan_ff + 1'b1;
            else nest_in = nest_ff - 1'b1;
         end
      end
   end

   always_comb begin
      stat            = '0;
      stat.need_scan  = !at_end && (sym == SYM_OPEN) && cell_zero;
      stat.scan_end   = (scan_ff >= run_len);
      stat.scan_hit   = (sym == SYM_CLOSE) && (nest_ff == NestOne);
      stat.clear_last = (clr_ff == TapeMax);
      stat.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff      <= '0;
         pc_ff        <= '0;
         ptr_ff       <= '0;
         depth_ff     <= '0;
         scan_ff      <= '0;
         nest_ff      <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) plen_ff <= csr_wr_data;
         pc_ff    <= pc_in;
         ptr_ff   <= ptr_in;
         depth_ff <= depth_in;
         scan_ff  <= scan_in;
         nest_ff  <= nest_in;
         clr_ff   <= clr_in;
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      res_ov_ff   <= res_ov_in;
      res_byte_ff <= res_byte_in;
      res_st_ff   <= res_st_in;
      if (cmd.emit) begin
         rsp_out_valid_ff    <= res_ov_ff;
         rsp_out_byte_ff     <= res_byte_ff;
         rsp_status_ff       <= res_st_ff;
         rsp_next_pc_ff      <= pc_ff;
         rsp_cell_pointer_ff <= ptr_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_valid    = rsp_out_valid_ff;
   assign rsp_out_byte     = rsp_out_byte_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_next_pc      = rsp_next_pc_ff;
   assign rsp_cell_pointer = rsp_cell_pointer_ff;

endmodule

// ===== sv/tape_machine_interpreter_core_unit.sv =====
// tape machine interpreter: one instruction of a stored bracket-loop program per step word.
// Timing: every word takes its own pass; a new word is taken only when the previous one has
// finished, while its result word may still wait in the output register. A load word goes
// straight from accept to result, a step word through accept, program/tape/stack read, execute
// and result, and an open bracket on a zero cell adds an issue and a check state for every
// program symbol that the forward scan walks through the single program store read port, plus
// a last issue state when the scan runs off the end of the program without a match. A restart
// word sweeps the 4096-cell tape one cell per cycle. After reset the same clearing pass runs
// before the first word is taken; csr writes are taken at any time.
module tape_machine_interpreter_core_unit import tmi_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   // configuration: program length
   input  logic                csr_wr_en,
   input  logic [PC_W-1:0]     csr_wr_data,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_opcode,
   input  logic [PROG_AW-1:0]  req_prog_addr,
   input  logic [2:0]          req_symbol,
   input  logic [CELL_W-1:0]   req_in_byte,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_out_valid,
   output logic [CELL_W-1:0]   rsp_out_byte,
   output logic [1:0]          rsp_status,
   output logic [PC_W-1:0]     rsp_next_pc,
   output logic [TAPE_AW-1:0]  rsp_cell_pointer
);

   cmd_type  cmd;
   stat_type stat;

   // controller sequences fetch, execute, bracket scan and tape clear
   tmi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .stat       (stat),
      .req_stall  (req_stall),
      .cmd        (cmd)
   );

   // datapath holds the stores, pointers and the output register
   tmi_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_prog_addr    (req_prog_addr),
      .req_symbol       (req_symbol),
      .req_in_byte      (req_in_byte),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_out_valid    (rsp_out_valid),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_status       (rsp_status),
      .rsp_next_pc      (rsp_next_pc),
      .rsp_cell_pointer (rsp_cell_pointer)
   );

endmodule

// ===== sv/tmi_checker.sv =====
// port-level checks for the interpreter and their binding to the top level
module tmi_checker import tmi_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_out_valid,
   input logic [CELL_W-1:0] rsp_out_byte,
   input logic [1:0]        rsp_status,
   input logic [PC_W-1:0]   rsp_next_pc
);

   // a stalled result word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   // one word in work at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous word in work");

   // a word with no print carries a zero byte
   a_quiet_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_valid |-> rsp_out_byte == '0)
      else $error("byte without print");

   // a print only comes from a step that completed normally
   a_print_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_valid |-> rsp_status == STAT_OK)
      else $error("print with error status");

   // the program position never passes the store depth
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_next_pc <= PC_W'(PROG_DEPTH))
      else $error("program position out of range");

endmodule

bind tape_machine_interpreter_core_unit tmi_checker u_tmi_checker (.*);

// ===== bench/tape_machine_interpreter_core_unit_tb.sv =====
// self-checking bench for the tape machine interpreter: random programs run against a shadow model
`timescale 1ns / 1ps

module tape_machine_interpreter_core_unit_tb;
   import tmi_pkg::*;

   // opcode 3 is not decoded by the block, it answers like a load
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int unsigned LEN_ALL_ONES = 8191;

   // one request word as it goes on the wire
   typedef struct {
      logic [1:0]         opcode;
      logic [PROG_AW-1:0] addr;
      symbol_type         sym;
      logic [CELL_W-1:0]  in_byte;
   } req_word_type;

   // one response word as the interpreter should report it
   typedef struct {
      logic               printed;
      logic [CELL_W-1:0]  out_byte;
      status_type         status;
      logic [PC_W-1:0]    next_pc;
      logic [TAPE_AW-1:0] pointer;
   } report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               csr_wr_en     = 1'b0;
   logic [PC_W-1:0]    csr_wr_data   = '0;
   logic               req_valid     = 1'b0;
   logic               req_stall;
   logic [1:0]         req_opcode    = '0;
   logic [PROG_AW-1:0] req_prog_addr = '0;
   logic [2:0]         req_symbol    = '0;
   logic [CELL_W-1:0]  req_in_byte   = '0;
   logic               rsp_valid;
   logic               rsp_stall     = 1'b0;
   logic               rsp_out_valid;
   logic [CELL_W-1:0]  rsp_out_byte;
   logic [1:0]         rsp_status;
   logic [PC_W-1:0]    rsp_next_pc;
   logic [TAPE_AW-1:0] rsp_cell_pointer;

   // words waiting to be sent, and reports the interpreter still owes us
   req_word_type pending_words[$];
   report_type   predicted_reports[$];
   req_word_type on_wire;
   symbol_type   program_text[$];

   int unsigned item_count   = 0;
   int          fail_count   = 0;
   int unsigned send_gap_pct = 0;
   int unsigned stall_pct    = 0;

   // shadow copy of the interpreter state
   symbol_type        shadow_prog [PROG_DEPTH];
   logic [CELL_W-1:0] shadow_tape [TAPE_CELLS];
   int unsigned       head       = 0;
   int unsigned       pc         = 0;
   int unsigned       nest_stack [LOOP_NEST];
   int unsigned       nest_depth = 0;
   int unsigned       length_reg = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   tape_machine_interpreter_core_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_prog_addr    (req_prog_addr),
      .req_symbol       (req_symbol),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_valid    (rsp_out_valid),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_status       (rsp_status),
      .rsp_next_pc      (rsp_next_pc),
      .rsp_cell_pointer (rsp_cell_pointer)
   );

   // apply one accepted word to the shadow state and return the report it must produce
   function automatic report_type interpret_word(req_word_type w);
      report_type        r;
      int unsigned       limit;
      int unsigned       nest;
      int unsigned       at;
      bit                found;
      logic [CELL_W-1:0] cur_byte;
      r.printed  = 1'b0;
      r.out_byte = '0;
      r.status   = STAT_OK;
      // the run never looks past the store, whatever the register says
      limit = (length_reg < PROG_DEPTH) ? length_reg : PROG_DEPTH;
      if (w.opcode == OP_LOAD) begin
         shadow_prog[w.addr] = w.sym;
      end else if (w.opcode == OP_RESTART) begin
         foreach (shadow_tape[i]) shadow_tape[i] = '0;
         head       = 0;
         pc         = 0;
         nest_depth = 0;
      end else if (w.opcode == OP_STEP) begin
         if (pc >= limit) begin
            // ran off the end: report it and touch nothing
            r.status = STAT_END;
         end else begin
            cur_byte = shadow_tape[head];
            case (shadow_prog[pc])
               SYM_RIGHT: begin
                  if (head < TAPE_CELLS - 1) head++;
                  pc++;
               end
               SYM_LEFT: begin
                  if (head > 0) head--;
                  pc++;
               end
               SYM_INC: begin
                  shadow_tape[head] = cur_byte + 1'b1;
                  pc++;
               end
               SYM_DEC: begin
                  shadow_tape[head] = cur_byte - 1'b1;
                  pc++;
               end
               SYM_PRINT: begin
                  r.printed  = 1'b1;
                  r.out_byte = cur_byte;
                  pc++;
               end
               SYM_READ: begin
                  shadow_tape[head] = w.in_byte;
                  pc++;
               end
               SYM_OPEN: begin
                  if (cur_byte != 0) begin
                     // entering the loop: remember where it starts unless the stack is full
                     if (nest_depth >= LOOP_NEST) begin
                        r.status = STAT_OVERFLOW;
                     end else begin
                        nest_stack[nest_depth] = pc;
                        nest_depth++;
                        pc++;
                     end
                  end else begin
                     // skipping the loop: walk forward to the matching close
                     nest  = 1;
                     found = 1'b0;
                     at    = 0;
                     for (int unsigned k = pc + 1; k < limit && !found; k++) begin
                        if (shadow_prog[k] == SYM_OPEN) begin
                           nest++;
                        end else if (shadow_prog[k] == SYM_CLOSE) begin
                           nest--;
                           if (nest == 0) begin
                              found = 1'b1;
                              at    = k;
                           end
                        end
                     end
                     if (found) pc = at + 1;
                     else r.status = STAT_UNMATCHED;
                  end
               end
               SYM_CLOSE: begin
                  if (nest_depth == 0) begin
                     r.status = STAT_UNMATCHED;
                  end else if (cur_byte != 0) begin
                     // loop back just past the open, the entry stays stacked
                     pc = nest_stack[nest_depth - 1] + 1;
                  end else begin
                     nest_depth--;
                     pc++;
                  end
               end
            endcase
         end
      end
      r.next_pc = pc[PC_W-1:0];
      r.pointer = head[TAPE_AW-1:0];
      return r;
   endfunction

   task automatic push_word(logic [1:0] opcode, int unsigned addr, int unsigned sym,
                            int unsigned in_byte);
      req_word_type w;
      w.opcode  = opcode;
      w.addr    = addr[PROG_AW-1:0];
      w.sym     = symbol_type'(sym[2:0]);
      w.in_byte = in_byte[CELL_W-1:0];
      pending_words.push_back(w);
      // ignored words do not count toward the stimulus size
      if (opcode != OP_UNUSED) item_count++;
   endtask

   // step with random junk in the fields the step does not use
   task automatic push_step(int unsigned in_byte);
      push_word(OP_STEP, $urandom_range(PROG_DEPTH - 1), $urandom_range(7), in_byte);
   endtask

   task automatic push_noise();
      push_word(OP_UNUSED, $urandom_range(PROG_DEPTH - 1), $urandom_range(7),
                $urandom_range(255));
   endtask

   // hold the sender until every owed report is in, then let the block settle
   task automatic wait_drained();
      while (pending_words.size() != 0 || req_valid || predicted_reports.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // program length register, written while the interpreter is idle and once during the clear after reset
   task automatic set_length(int unsigned value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[PC_W-1:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      length_reg  = value;
   endtask

   // one program: load it, restart the run, set its length, then step through it
   task automatic run_random_phase(bit nest_test);
      int unsigned n;
      int unsigned d;
      int unsigned len;
      int unsigned steps;
      int unsigned r;
      int unsigned open_now;
      bit          well_formed;
      symbol_type  s;
      program_text.delete();
      if (nest_test || $urandom_range(11) == 0) begin
         // deep nesting around the stack size: set a cell, open d loops, clear, close them
         d = nest_test ? $urandom_range(LOOP_NEST + 1, LOOP_NEST + 4)
                       : $urandom_range(LOOP_NEST - 3, LOOP_NEST + 3);
         program_text.push_back(SYM_INC);
         repeat (d) program_text.push_back(SYM_OPEN);
         program_text.push_back(SYM_DEC);
         repeat (d) program_text.push_back(SYM_CLOSE);
      end else begin
         n           = ($urandom_range(9) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(2, 40);
         well_formed = ($urandom_range(4) != 0);
         open_now    = 0;
         for (int unsigned i = 0; i < n; i++) begin
            if (!well_formed) begin
               s = symbol_type'($urandom_range(7));
            end else if (n - i <= open_now) begin
               // close whatever is still open
               s = SYM_CLOSE;
            end else begin
               r = $urandom_range(99);
               if (r < 18)      s = SYM_INC;
               else if (r < 38) s = SYM_DEC;
               else if (r < 50) s = SYM_RIGHT;
               else if (r < 60) s = SYM_LEFT;
               else if (r < 72) s = SYM_PRINT;
               else if (r < 78) s = SYM_READ;
               else if (r < 89) s = SYM_OPEN;
               else             s = (open_now != 0) ? SYM_CLOSE : SYM_DEC;
               // no room left to close a new loop
               if (s == SYM_OPEN && n - i - 1 <= open_now) s = SYM_INC;
            end
            if (s == SYM_OPEN) open_now++;
            else if (s == SYM_CLOSE && open_now != 0) open_now--;
            program_text.push_back(s);
         end
      end
      n = program_text.size();
      foreach (program_text[a]) begin
         if ($urandom_range(19) == 0) push_noise();
         push_word(OP_LOAD, a, program_text[a], $urandom_range(255));
      end
      push_word(OP_RESTART, $urandom_range(PROG_DEPTH - 1), $urandom_range(7),
                $urandom_range(255));
      wait_drained();
      // mostly the whole program, sometimes a cut short run
      len = ($urandom_range(7) == 0) ? $urandom_range(n) : n;
      set_length(len);
      steps = 2 * n + $urandom_range(40);
      if (steps > 180) steps = 180;
      repeat (steps) begin
         r = $urandom_range(99);
         if (r < 3)      push_noise();
         else if (r < 6) push_word(OP_LOAD, $urandom_range(PROG_DEPTH - 1), $urandom_range(7),
                                   $urandom_range(255));
         else            push_step($urandom_range(255));
      end
   endtask

   // driver: present the next word once the current one is taken, with random gaps
   always @(posedge clock) begin : send_words
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // accepted at this edge: predict its report now, in acceptance order
         if (req_valid && !req_stall)
            predicted_reports.push_back(interpret_word(on_wire));
         // a stalled word holds still, otherwise pick the next one or idle
         if (!req_valid || !req_stall) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               on_wire        = pending_words.pop_front();
               req_valid     <= 1'b1;
               req_opcode    <= on_wire.opcode;
               req_prog_addr <= on_wire.addr;
               req_symbol    <= on_wire.sym;
               req_in_byte   <= on_wire.in_byte;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string what, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         fail_count++;
      end
   endtask

   // monitor: take each report word and compare it with the oldest prediction
   always @(posedge clock) begin : watch_reports
      report_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_reports.size() == 0) begin
               $display("%0t ns: stray report, expected none, actual pc %0h pointer %0h",
                        $time, rsp_next_pc, rsp_cell_pointer);
               fail_count++;
            end else begin
               want = predicted_reports.pop_front();
               check_field("out_valid", want.printed, rsp_out_valid);
               check_field("out_byte", want.out_byte, rsp_out_byte);
               check_field("status", want.status, rsp_status);
               check_field("next_pc", want.next_pc, rsp_next_pc);
               check_field("cell_pointer", want.pointer, rsp_cell_pointer);
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   initial begin : stimulus
      int unsigned goal;
      symbol_type  warmup [11] = '{SYM_LEFT, SYM_DEC, SYM_PRINT, SYM_READ, SYM_OPEN, SYM_INC,
                                   SYM_CLOSE, SYM_CLOSE, SYM_OPEN, SYM_DEC, SYM_CLOSE};
      foreach (shadow_tape[i]) shadow_tape[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // sender sparse, receiver stalls often
      send_gap_pct = 32;
      stall_pct    = 46;

      // directed: empty program first
      set_length(0);
      push_step(255);
      push_noise();
      foreach (warmup[a]) push_word(OP_LOAD, a, warmup[a], $urandom_range(255));
      wait_drained();
      set_length(11);
      // left held at zero, dec wraps to 255, print shows it
      repeat (3) push_step($urandom_range(255));
      // read clears the cell
      push_step(0);
      // open on a zero cell skips its loop, then a close with nothing stacked
      repeat (2) push_step($urandom_range(255));
      // open on a zero cell whose close lies beyond the length
      push_word(OP_LOAD, 7, SYM_OPEN, 0);
      push_step($urandom_range(255));
      // a two-pass loop: read 2, open, dec, close back, dec, close out, then the end
      push_word(OP_LOAD, 7, SYM_READ, 0);
      push_step(2);
      repeat (6) push_step($urandom_range(255));
      push_word(OP_RESTART, PROG_DEPTH - 1, SYM_CLOSE, 255);
      wait_drained();

      // random programs, the first one nests deeper than the loop stack
      goal = item_count + 520;
      run_random_phase(1'b1);
      while (item_count < goal) run_random_phase(1'b0);

      // sender idles more than the receiver stalls
      send_gap_pct = 46;
      stall_pct    = 32;
      goal = item_count + 520;
      while (item_count < goal) run_random_phase(1'b0);

      // no idling from here on
      wait_drained();
      send_gap_pct = 0;
      stall_pct    = 0;

      // a length beyond the store is clipped to the store
      push_word(OP_LOAD, 0, SYM_RIGHT, 0);
      push_word(OP_RESTART, 0, SYM_RIGHT, 0);
      wait_drained();
      set_length(LEN_ALL_ONES);
      push_step($urandom_range(255));

      goal = item_count + 520;
      while (item_count < goal) run_random_phase(1'b0);

      wait_drained();
      repeat (56) @(posedge clock);
      if (fail_count == 0)
         $display("PASS tape_machine_interpreter_core_unit");
      else
         $display("FAIL tape_machine_interpreter_core_unit");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin : watchdog
      #100_000_000;
      $display("FAIL tape_machine_interpreter_core_unit");
      $finish;
   end

endmodule
